// ===== rtl/nttab_pkg.sv =====
// ----------------------------------------------------------------------------
// nttab_pkg
// Shared types and constants of the nearest track table.
// ----------------------------------------------------------------------------
package nttab_pkg;

    localparam int MAX_TRACKS = 16;
    localparam int SLOT_W     = $clog2(MAX_TRACKS);
    localparam int COUNT_W    = $clog2(MAX_TRACKS + 1);
    localparam int COORD_W    = 16;
    localparam int TICK_W     = 16;
    localparam int DIST_W     = 33;
    localparam int IN_W       = 56;
    localparam int OUT_W      = 88;

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_NEAREST = 3'd1;
    localparam logic [2:0] CMD_REPLACE = 3'd2;
    localparam logic [2:0] CMD_KILL    = 3'd3;
    localparam logic [2:0] CMD_TICK    = 3'd4;
    localparam logic [2:0] CMD_SWEEP   = 3'd5;
    localparam logic [2:0] CMD_QUERY   = 3'd6;
    localparam logic [2:0] CMD_UNUSED  = 3'd7;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_FULL   = 2'd1;
    localparam logic [1:0] ERR_UNUSED = 2'd2;

    localparam logic CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic CFG_FAR_DISTANCE = 1'b1;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef struct packed {
        logic                valid;
        logic [2:0]          cmd;
        logic [3:0]          slot;
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [COORD_W-1:0]  rad;
        logic [COUNT_W-1:0]  used;
        logic [DIST_W-1:0]   best;
        logic [SLOT_W-1:0]   bslot;
        logic                alive;
        logic [TICK_W-1:0]   age;
        logic [TICK_W-1:0]   idle;
        logic [DIST_W-1:0]   dsq;
        logic [COUNT_W-1:0]  active;
    } token_t;

endpackage

// ===== rtl/nttab_cell.sv =====
// ----------------------------------------------------------------------------
// nttab_cell
// One track slot: applies the passing command token to its own track and
// hands the updated token to the next slot.
// ----------------------------------------------------------------------------
module nttab_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [nttab_pkg::SLOT_W-1:0]  idx,
    input  logic [nttab_pkg::TICK_W-1:0]  idle_timeout,
    input  nttab_pkg::token_t             tin,
    output nttab_pkg::token_t             tout
);

    logic [nttab_pkg::COORD_W-1:0] x_reg, x_next, y_reg, y_next, r_reg, r_next;
    logic                          alive_reg, alive_next;
    logic [nttab_pkg::TICK_W-1:0]  age_reg, age_next, idle_reg, idle_next;
    nttab_pkg::token_t             tout_reg, t;

    logic [nttab_pkg::COORD_W-1:0] dx, dy;
    logic [31:0]                   sx, sy;
    logic [nttab_pkg::DIST_W-1:0]  d;
    logic                          in_use, is_slot, counted;

    always_comb
    begin
        dx = (tin.cx >= x_reg) ? tin.cx - x_reg : x_reg - tin.cx;
        dy = (tin.cy >= y_reg) ? tin.cy - y_reg : y_reg - tin.cy;
        sx = dx * dx;
        sy = dy * dy;
        d  = {1'b0, sx} + {1'b0, sy};
    end

    always_comb
    begin
        in_use     = {1'b0, idx} < tin.used;
        is_slot    = in_use && ({{(4-nttab_pkg::SLOT_W){1'b0}}, idx} == tin.slot);
        counted    = in_use || (tin.cmd == nttab_pkg::CMD_ADD && {1'b0, idx} == tin.used);
        x_next     = x_reg;
        y_next     = y_reg;
        r_next     = r_reg;
        alive_next = alive_reg;
        age_next   = age_reg;
        idle_next  = idle_reg;
        t          = tin;
        if (tin.valid)
        begin
            case (tin.cmd)
                nttab_pkg::CMD_ADD:
                begin
                    if ({1'b0, idx} == tin.used)
                    begin
                        x_next     = tin.cx;
                        y_next     = tin.cy;
                        r_next     = tin.rad;
                        alive_next = 1'b1;
                        age_next   = '0;
                        idle_next  = '0;
                        t.alive    = 1'b1;
                        t.age      = '0;
                        t.idle     = '0;
                        t.dsq      = '0;
                    end
                end
                nttab_pkg::CMD_NEAREST:
                begin
                    if (in_use && (idx == '0 || d < tin.best))
                    begin
                        t.alive = alive_reg;
                        t.age   = age_reg;
                        t.idle  = idle_reg;
                        t.dsq   = d;
                    end
                    if (in_use && d < tin.best)
                    begin
                        t.best  = d;
                        t.bslot = idx;
                    end
                end
                nttab_pkg::CMD_REPLACE:
                begin
                    if (is_slot)
                    begin
                        x_next    = tin.cx;
                        y_next    = tin.cy;
                        r_next    = tin.rad;
                        idle_next = '0;
                        t.alive   = alive_reg;
                        t.age     = age_reg;
                        t.idle    = '0;
                        t.dsq     = '0;
                    end
                end
                nttab_pkg::CMD_KILL:
                begin
                    if (is_slot)
                    begin
                        alive_next = 1'b0;
                        t.alive    = 1'b0;
                        t.age      = age_reg;
                        t.idle     = idle_reg;
                        t.dsq      = d;
                    end
                end
                nttab_pkg::CMD_QUERY:
                begin
                    if (is_slot)
                    begin
                        t.alive = alive_reg;
                        t.age   = age_reg;
                        t.idle  = idle_reg;
                        t.dsq   = d;
                    end
                end
                nttab_pkg::CMD_TICK:
                begin
                    if (in_use)
                    begin
                        age_next  = (age_reg == nttab_pkg::TICK_MAX) ? age_reg : age_reg + 1'b1;
                        idle_next = (idle_reg == nttab_pkg::TICK_MAX) ? idle_reg
                                                                      : idle_reg + 1'b1;
                    end
                end
                nttab_pkg::CMD_SWEEP:
                begin
                    if (in_use && idle_reg > idle_timeout)
                        alive_next = 1'b0;
                end
                default:
                begin
                end
            endcase
            if (counted && alive_next)
                t.active = tin.active + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        r_reg     <= r_next;
        alive_reg <= alive_next;
        age_reg   <= age_next;
        idle_reg  <= idle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tout_reg <= '0;
        else
            tout_reg <= t;
    end

    assign tout = tout_reg;

endmodule

// ===== rtl/nearest_track_table_core.sv =====
// ----------------------------------------------------------------------------
// nearest_track_table_core
// Table of 16 object tracks with nearest-centre search, built as a chain of
// slot cells through which each command travels.
// ----------------------------------------------------------------------------
// Each command passes through all 16 slot cells, one cell per clock. The
// result then goes to the output register, or to a hold register while the
// output stalls. One command is in the chain at a time; the next is taken as
// soon as the previous result has been moved to the output register.
module nearest_track_table_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // command[2:0], slot[6:3], center_x[22:7], center_y[38:23], radius[54:39]
    input  logic [nttab_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // result_slot[3:0], distance_sq[36:4], slot_alive[37], slot_age[53:38],
    // slot_idle[69:54], active_count[74:70], track_count[79:75], error[81:80]
    output logic [nttab_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [nttab_pkg::DIST_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [nttab_pkg::TICK_W-1:0]    timeout_reg;
    logic [nttab_pkg::DIST_W-1:0]    far_reg;
    logic [nttab_pkg::COUNT_W-1:0]   used_reg, used_next;
    logic                            out_valid_reg;
    logic [nttab_pkg::OUT_W-1:0]     out_data_reg, hold_reg, res;
    nttab_pkg::token_t               inj;
    nttab_pkg::token_t               chain [nttab_pkg::MAX_TRACKS+1];
    nttab_pkg::token_t               e;
    logic                            accept, out_free;
    logic [1:0]                      err;
    logic                            have, add_ok;
    logic [3:0]                      rslot;
    logic [nttab_pkg::COUNT_W-1:0]   tcount;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        inj        = '0;
        inj.valid  = accept;
        inj.cmd    = s_axis_tdata[2:0];
        inj.slot   = s_axis_tdata[6:3];
        inj.cx     = s_axis_tdata[22:7];
        inj.cy     = s_axis_tdata[38:23];
        inj.rad    = s_axis_tdata[54:39];
        inj.used   = used_reg;
        inj.best   = far_reg;
        used_next  = used_reg;
        if (accept && inj.cmd == nttab_pkg::CMD_ADD
            && used_reg < nttab_pkg::COUNT_W'(nttab_pkg::MAX_TRACKS))
            used_next = used_reg + 1'b1;
    end

    assign chain[0] = inj;

    for (genvar i = 0; i < nttab_pkg::MAX_TRACKS; i++)
    begin : g_cell
        nttab_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .idx          (nttab_pkg::SLOT_W'(i)),
            .idle_timeout (timeout_reg),
            .tin          (chain[i]),
            .tout         (chain[i+1])
        );
    end

    assign e = chain[nttab_pkg::MAX_TRACKS];

    always_comb
    begin
        err    = nttab_pkg::ERR_OK;
        add_ok = 1'b0;
        rslot  = '0;
        case (e.cmd)
            nttab_pkg::CMD_ADD:
            begin
                if (e.used >= nttab_pkg::COUNT_W'(nttab_pkg::MAX_TRACKS))
                    err = nttab_pkg::ERR_FULL;
                else
                begin
                    add_ok = 1'b1;
                    rslot  = 4'(e.used);
                end
            end
            nttab_pkg::CMD_NEAREST:
            begin
                rslot = 4'(e.bslot);
                if (e.used == '0)
                    err = nttab_pkg::ERR_UNUSED;
            end
            nttab_pkg::CMD_REPLACE, nttab_pkg::CMD_KILL, nttab_pkg::CMD_QUERY:
            begin
                rslot = e.slot;
                if ({1'b0, e.slot} >= e.used)
                    err = nttab_pkg::ERR_UNUSED;
            end
            default:
            begin
            end
        endcase
        have   = (err == nttab_pkg::ERR_OK) && (e.cmd != nttab_pkg::CMD_TICK)
                 && (e.cmd != nttab_pkg::CMD_SWEEP) && (e.cmd != nttab_pkg::CMD_UNUSED);
        tcount = e.used + {{(nttab_pkg::COUNT_W-1){1'b0}}, add_ok};
        res    = '0;
        res[3:0]   = rslot;
        res[36:4]  = have ? e.dsq : '0;
        res[37]    = have ? e.alive : 1'b0;
        res[53:38] = have ? e.age : '0;
        res[69:54] = have ? e.idle : '0;
        res[74:70] = 5'(e.active);
        res[79:75] = 5'(tcount);
        res[81:80] = err;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RUN;
            ST_RUN:  if (e.valid) state_next = out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            timeout_reg   <= nttab_pkg::TICK_W'(5);
            far_reg       <= nttab_pkg::DIST_W'(256000000);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (cfg_we)
            begin
                if (cfg_index == nttab_pkg::CFG_IDLE_TIMEOUT)
                    timeout_reg <= cfg_data[nttab_pkg::TICK_W-1:0];
                else
                    far_reg <= cfg_data;
            end
            if ((state_reg == ST_RUN && e.valid) || state_reg == ST_HOLD)
            begin
                if (out_free)
                    out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RUN && e.valid)
        begin
            hold_reg <= res;
            if (out_free)
                out_data_reg <= res;
        end
        else if (state_reg == ST_HOLD && out_free)
            out_data_reg <= hold_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== rtl/nttab_checker.sv =====
// ----------------------------------------------------------------------------
// nttab_checker
// Port-level checks of the nearest track table, bound to the top level.
// ----------------------------------------------------------------------------
module nttab_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [nttab_pkg::OUT_W-1:0]  m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[81:80] != 2'd3)
        else $error("bad error code");

    a_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[74:70] <= m_axis_tdata[79:75])
        else $error("active count above track count");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[79:75] <= 5'(nttab_pkg::MAX_TRACKS))
        else $error("track count above table size");

endmodule

bind nearest_track_table_core nttab_checker u_nttab_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
